@@ sv/rhsv_pkg.sv @@
// Shared types and constants for the RGB to HSV converter.
// No dependencies.
`default_nettype none

package rhsv_pkg;

	localparam int SAT_BITS = 8;

	typedef struct packed {
		logic hue_zero;
		logic sat_zero;
	} pix_flags_t;

endpackage

`default_nettype wire

@@ sv/rhsv_front.sv @@
// Front end of the converter: max/min search, sextant numerator and divider operands.
// Three register stages. Depends on rhsv_pkg.
`default_nettype none

module rhsv_front #(
	parameter int CB = 8,
	parameter int H  = 16
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               en,
	input  wire logic                               in_vld,
	input  wire logic [CB-1:0]                      red,
	input  wire logic [CB-1:0]                      green,
	input  wire logic [CB-1:0]                      blue,
	output logic                                    out_vld,
	output logic [CB+H+2:0]                         hue_dvd,
	output logic [CB+2:0]                           hue_dvs,
	output logic [CB+rhsv_pkg::SAT_BITS-1:0]        sat_dvd,
	output logic [CB-1:0]                           sat_dvs,
	output rhsv_pkg::pix_flags_t                    flags
);
	import rhsv_pkg::*;

	localparam int NW = CB + 3;
	localparam int EW = CB + 3 + H;
	localparam int SW = CB + SAT_BITS;

	typedef enum logic [1:0] {
		MAX_RED,
		MAX_GREEN,
		MAX_BLUE
	} max_ch_t;

	// stage 1: order the channels
	logic          vld_s1;
	logic [CB-1:0] r_s1, g_s1, b_s1, mx_s1, mn_s1;
	max_ch_t       sel_s1;
	logic [CB-1:0] mx_c, mn_c;
	max_ch_t       sel_c;

	always_comb begin
		if (red >= green && red >= blue) begin
			sel_c = MAX_RED;
			mx_c  = red;
		end else if (green >= blue) begin
			sel_c = MAX_GREEN;
			mx_c  = green;
		end else begin
			sel_c = MAX_BLUE;
			mx_c  = blue;
		end
		mn_c = red;
		if (green < mn_c) mn_c = green;
		if (blue < mn_c) mn_c = blue;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			r_s1   <= red;
			g_s1   <= green;
			b_s1   <= blue;
			mx_s1  <= mx_c;
			mn_s1  <= mn_c;
			sel_s1 <= sel_c;
		end
	end

	// stage 2: chroma and sextant numerator
	logic          vld_s2;
	logic [CB-1:0] d_s2, mx_s2;
	logic [NW-1:0] num_s2;
	pix_flags_t    flags_s2;
	logic [CB-1:0] d_c;
	logic [NW-1:0] dn, rn, gn, bn, num_c;

	always_comb begin
		d_c = mx_s1 - mn_s1;
		dn  = NW'(d_c);
		rn  = NW'(r_s1);
		gn  = NW'(g_s1);
		bn  = NW'(b_s1);
		unique case (sel_s1)
			MAX_RED: begin
				if (g_s1 >= b_s1) num_c = gn - bn;
				else num_c = (dn << 2) + (dn << 1) - (bn - gn);
			end
			MAX_GREEN: num_c = (dn << 1) + bn - rn;
			MAX_BLUE:  num_c = (dn << 2) + rn - gn;
			default:   num_c = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d_s2              <= d_c;
			mx_s2             <= mx_s1;
			num_s2            <= num_c;
			flags_s2.hue_zero <= (d_c == '0);
			flags_s2.sat_zero <= (mx_s1 == '0);
		end
	end

	// stage 3: dividends with rounding terms, divisors
	logic          vld_s3;
	logic [EW-1:0] hue_dvd_s3;
	logic [NW-1:0] hue_dvs_s3;
	logic [SW-1:0] sat_dvd_s3;
	logic [CB-1:0] mx_s3;
	pix_flags_t    flags_s3;
	logic [NW-1:0] d6;
	logic [EW-1:0] d3e;
	logic [SW-1:0] dse;

	always_comb begin
		d6  = (NW'(d_s2) << 2) + (NW'(d_s2) << 1);
		d3e = (EW'(d_s2) << 1) + EW'(d_s2);
		dse = SW'(d_s2);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			hue_dvd_s3 <= {num_s2, {H{1'b0}}} + d3e;
			hue_dvs_s3 <= d6;
			sat_dvd_s3 <= (dse << SAT_BITS) - dse + SW'(mx_s2 >> 1);
			mx_s3      <= mx_s2;
			flags_s3   <= flags_s2;
		end
	end

	assign out_vld = vld_s3;
	assign hue_dvd = hue_dvd_s3;
	assign hue_dvs = hue_dvs_s3;
	assign sat_dvd = sat_dvd_s3;
	assign sat_dvs = mx_s3;
	assign flags   = flags_s3;

endmodule

`default_nettype wire

@@ sv/rhsv_divstep.sv @@
// Restoring division steps: brings down STEP dividend bits, one quotient bit each.
// Combinational. No dependencies.
`default_nettype none

module rhsv_divstep #(
	parameter int D    = 11,
	parameter int QP   = 18,
	parameter int STEP = 2
) (
	input  wire logic [D-1:0]  rem,
	input  wire logic [QP-1:0] lo,
	input  wire logic [D-1:0]  dvs,
	output logic      [D-1:0]  rem_next,
	output logic      [QP-1:0] lo_next
);

	// lo holds the dividend bits still to come, quotient bits fill in from the bottom
	always_comb begin
		logic [D-1:0]  r;
		logic [QP-1:0] l;
		logic [D:0]    t;
		logic          q;
		r = rem;
		l = lo;
		for (int i = 0; i < STEP; i++) begin
			t = {r, l[QP-1]};
			if (t >= {1'b0, dvs}) begin
				r = D'(t - {1'b0, dvs});
				q = 1'b1;
			end else begin
				r = t[D-1:0];
				q = 1'b0;
			end
			l = {l[QP-2:0], q};
		end
		rem_next = r;
		lo_next  = l;
	end

endmodule

`default_nettype wire

@@ sv/rhsv_divpipe.sv @@
// Pipelined hue and saturation dividers, side data carried alongside.
// Depends on rhsv_pkg and rhsv_divstep.
`default_nettype none

module rhsv_divpipe #(
	parameter int CB = 8,
	parameter int H  = 16
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               en,
	input  wire logic                               in_vld,
	input  wire logic [CB+H+2:0]                    hue_dvd,
	input  wire logic [CB+2:0]                      hue_dvs,
	input  wire logic [CB+rhsv_pkg::SAT_BITS-1:0]   sat_dvd,
	input  wire logic [CB-1:0]                      sat_dvs,
	input  rhsv_pkg::pix_flags_t                    in_flags,
	output logic                                    out_vld,
	output logic [H-1:0]                            out_hue,
	output logic [rhsv_pkg::SAT_BITS-1:0]           out_sat,
	output logic [CB-1:0]                           out_bright,
	output rhsv_pkg::pix_flags_t                    out_flags
);
	import rhsv_pkg::*;

	localparam int HD     = CB + 3;
	localparam int HQ     = H + 1;
	localparam int STAGES = (HQ + 1) / 2;
	localparam int HSTEP  = (HQ + STAGES - 1) / STAGES;
	localparam int HQP    = STAGES * HSTEP;
	localparam int SD     = CB;
	localparam int SSTEP  = (SAT_BITS + STAGES - 1) / STAGES;
	localparam int SQP    = STAGES * SSTEP;

	logic [HD+HQP-1:0] hue_ext;
	logic [SD+SQP-1:0] sat_ext;

	assign hue_ext = (HD + HQP)'(hue_dvd);
	assign sat_ext = (SD + SQP)'(sat_dvd);

	logic           vld_s   [STAGES];
	logic [HD-1:0]  hrem_s  [STAGES];
	logic [HQP-1:0] hlo_s   [STAGES];
	logic [HD-1:0]  hdvs_s  [STAGES];
	logic [SD-1:0]  srem_s  [STAGES];
	logic [SQP-1:0] slo_s   [STAGES];
	logic [SD-1:0]  sdvs_s  [STAGES];
	pix_flags_t     flags_s [STAGES];

	for (genvar k = 0; k < STAGES; k++) begin : g_stage
		logic           vld_in;
		logic [HD-1:0]  hrem_in, hdvs_in, hrem_nx;
		logic [HQP-1:0] hlo_in, hlo_nx;
		logic [SD-1:0]  srem_in, sdvs_in, srem_nx;
		logic [SQP-1:0] slo_in, slo_nx;
		pix_flags_t     flags_in;

		if (k == 0) begin : g_head
			assign vld_in   = in_vld;
			assign hrem_in  = hue_ext[HD+HQP-1:HQP];
			assign hlo_in   = hue_ext[HQP-1:0];
			assign hdvs_in  = hue_dvs;
			assign srem_in  = sat_ext[SD+SQP-1:SQP];
			assign slo_in   = sat_ext[SQP-1:0];
			assign sdvs_in  = sat_dvs;
			assign flags_in = in_flags;
		end else begin : g_body
			assign vld_in   = vld_s[k-1];
			assign hrem_in  = hrem_s[k-1];
			assign hlo_in   = hlo_s[k-1];
			assign hdvs_in  = hdvs_s[k-1];
			assign srem_in  = srem_s[k-1];
			assign slo_in   = slo_s[k-1];
			assign sdvs_in  = sdvs_s[k-1];
			assign flags_in = flags_s[k-1];
		end

		rhsv_divstep #(.D(HD), .QP(HQP), .STEP(HSTEP)) u_hstep (
			.rem      (hrem_in),
			.lo       (hlo_in),
			.dvs      (hdvs_in),
			.rem_next (hrem_nx),
			.lo_next  (hlo_nx)
		);

		rhsv_divstep #(.D(SD), .QP(SQP), .STEP(SSTEP)) u_sstep (
			.rem      (srem_in),
			.lo       (slo_in),
			.dvs      (sdvs_in),
			.rem_next (srem_nx),
			.lo_next  (slo_nx)
		);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (en) begin
				vld_s[k] <= vld_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				hrem_s[k]  <= hrem_nx;
				hlo_s[k]   <= hlo_nx;
				hdvs_s[k]  <= hdvs_in;
				srem_s[k]  <= srem_nx;
				slo_s[k]   <= slo_nx;
				sdvs_s[k]  <= sdvs_in;
				flags_s[k] <= flags_in;
			end
		end
	end

	// quotient mod 2^H gives the wrap of a full turn
	assign out_vld    = vld_s[STAGES-1];
	assign out_hue    = hlo_s[STAGES-1][H-1:0];
	assign out_sat    = slo_s[STAGES-1][SAT_BITS-1:0];
	assign out_bright = sdvs_s[STAGES-1];
	assign out_flags  = flags_s[STAGES-1];

endmodule

`default_nettype wire

@@ sv/rgb_to_hsv_converter.sv @@
// Top level of the RGB to HSV pixel converter: stream ports and output register.
// Depends on rhsv_pkg, rhsv_front and rhsv_divpipe.
`default_nettype none

// One pixel is accepted every clock while the output is not stalled, and one
// HSV word leaves per pixel, in order. The pipe holds three front stages
// (max/min, sextant numerator, operands), the hue divider that resolves two
// quotient bits per stage, and the output register. The whole pipe advances
// when the output register is empty or being taken, so s_tready is low only
// while a result waits at a stalled output.

module rgb_to_hsv_converter #(
	parameter int CHANNEL_BITS = 8,
	parameter int HUE_BITS     = 16
) (
	input  wire logic                                           clk,
	input  wire logic                                           arst_n,
	input  wire logic                                           s_tvalid,
	output logic                                                s_tready,
	// red, green, blue
	input  wire logic [((3*CHANNEL_BITS+7)/8)*8-1:0]            s_tdata,
	output logic                                                m_tvalid,
	input  wire logic                                           m_tready,
	// hue, saturation, brightness
	output logic [((HUE_BITS+rhsv_pkg::SAT_BITS+CHANNEL_BITS+7)/8)*8-1:0] m_tdata
);
	import rhsv_pkg::*;

	localparam int CB    = CHANNEL_BITS;
	localparam int H     = HUE_BITS;
	localparam int OUT_W = ((H + SAT_BITS + CB + 7) / 8) * 8;

	logic en;

	logic                 f_vld;
	logic [CB+H+2:0]      f_hue_dvd;
	logic [CB+2:0]        f_hue_dvs;
	logic [CB+SAT_BITS-1:0] f_sat_dvd;
	logic [CB-1:0]        f_sat_dvs;
	pix_flags_t           f_flags;

	logic                 d_vld;
	logic [H-1:0]         d_hue;
	logic [SAT_BITS-1:0]  d_sat;
	logic [CB-1:0]        d_bright;
	pix_flags_t           d_flags;

	logic                 vld_q;
	logic [H-1:0]         hue_q;
	logic [SAT_BITS-1:0]  sat_q;
	logic [CB-1:0]        bright_q;

	assign en       = !vld_q || m_tready;
	assign s_tready = en;

	rhsv_front #(.CB(CB), .H(H)) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_vld  (s_tvalid),
		.red     (s_tdata[CB-1:0]),
		.green   (s_tdata[2*CB-1:CB]),
		.blue    (s_tdata[3*CB-1:2*CB]),
		.out_vld (f_vld),
		.hue_dvd (f_hue_dvd),
		.hue_dvs (f_hue_dvs),
		.sat_dvd (f_sat_dvd),
		.sat_dvs (f_sat_dvs),
		.flags   (f_flags)
	);

	rhsv_divpipe #(.CB(CB), .H(H)) u_div (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (en),
		.in_vld     (f_vld),
		.hue_dvd    (f_hue_dvd),
		.hue_dvs    (f_hue_dvs),
		.sat_dvd    (f_sat_dvd),
		.sat_dvs    (f_sat_dvs),
		.in_flags   (f_flags),
		.out_vld    (d_vld),
		.out_hue    (d_hue),
		.out_sat    (d_sat),
		.out_bright (d_bright),
		.out_flags  (d_flags)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (en) begin
			vld_q <= d_vld;
		end
	end

	// grey pixel: no hue; black pixel: no saturation
	always_ff @(posedge clk) begin
		if (en) begin
			hue_q    <= d_flags.hue_zero ? '0 : d_hue;
			sat_q    <= d_flags.sat_zero ? '0 : d_sat;
			bright_q <= d_bright;
		end
	end

	assign m_tvalid = vld_q;
	assign m_tdata  = OUT_W'({bright_q, sat_q, hue_q});

endmodule

`default_nettype wire

@@ sv/rhsv_chk.sv @@
// Port-level checks for rgb_to_hsv_converter, bound to the top level.
// Depends on rhsv_pkg.
`default_nettype none

module rhsv_chk #(
	parameter int CHANNEL_BITS = 8,
	parameter int HUE_BITS     = 16
) (
	input wire logic                                           clk,
	input wire logic                                           arst_n,
	input wire logic                                           s_tvalid,
	input wire logic                                           s_tready,
	input wire logic [((3*CHANNEL_BITS+7)/8)*8-1:0]            s_tdata,
	input wire logic                                           m_tvalid,
	input wire logic                                           m_tready,
	input wire logic [((HUE_BITS+rhsv_pkg::SAT_BITS+CHANNEL_BITS+7)/8)*8-1:0] m_tdata
);
	import rhsv_pkg::*;

	localparam int SL = HUE_BITS;
	localparam int BL = HUE_BITS + SAT_BITS;

	logic [HUE_BITS-1:0]     c_hue;
	logic [SAT_BITS-1:0]     c_sat;
	logic [CHANNEL_BITS-1:0] c_bright;

	assign c_hue     = m_tdata[SL-1:0];
	assign c_sat     = m_tdata[BL-1:SL];
	assign c_bright  = m_tdata[BL+CHANNEL_BITS-1:BL];

	a_ready_follows_out: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready == (!m_tvalid || m_tready))
		else $error("s_tready does not track output space");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("stalled word changed");

	a_black: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && c_bright == '0 |-> c_sat == '0 && c_hue == '0)
		else $error("black pixel with hue or saturation");

	a_no_stall_input: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled with empty output");

	a_in_known: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |-> !$isunknown(s_tdata))
		else $error("unknown bits in accepted input word");

endmodule

bind rgb_to_hsv_converter rhsv_chk #(
	.CHANNEL_BITS (CHANNEL_BITS),
	.HUE_BITS     (HUE_BITS)
) u_rhsv_chk (.*);

`default_nettype wire
